// ===== hw/rtl/mask_contour_pixel_extract_defines.svh =====
// Assertion helpers for the contour extractor RTL module.
// Every assertion is sampled on the rising edge of clock and is off while reset is high.
`ifndef MASK_CONTOUR_PIXEL_EXTRACT_DEFINES_SVH
`define MASK_CONTOUR_PIXEL_EXTRACT_DEFINES_SVH

// Same-cycle implication.
`define MCPE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MCPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mcpe_pkg.sv =====
`default_nettype none

package mcpe_pkg;

   // Field and register widths
   localparam int PIXEL_W   = 8;
   localparam int DIM_REG_W = 13;
   localparam int ORIGIN_W  = 16;
   localparam int POINT_W   = 17;
   localparam int ROW_W     = 12;
   // Compare width for column and row limits (covers a width of up to 65536)
   localparam int DIM_W     = 17;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ORIGIN_X     = 2'd2,
      CSR_ORIGIN_Y     = 2'd3
   } csr_index_type;

   // One contour point as it sits in the output buffer
   typedef struct packed {
      logic [POINT_W-1:0] point_y;
      logic [POINT_W-1:0] point_x;
   } point_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mcpe_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module mcpe_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mask_contour_pixel_extract.sv =====
`default_nettype none

// Contour point extractor for a binary mask streamed in raster order, one pixel per beat on
// req_. A pixel is painted when nonzero; a painted pixel with at least one empty neighbor in
// its 3x3 neighborhood is reported on rsp_ as (column + origin_x, row + origin_y). Border rows
// and columns are never reported. The block takes one pixel per clock while the output buffer
// has room: the two previous rows live in one line store RAM that is read at the new pixel's
// column in the accept cycle and written back at that column the following cycle, one read and
// one write per clock. A point is formed from stage 1 and pushed into a two-beat output buffer,
// from which it leaves on rsp_; req_tready drops only when that buffer, counting the pixel
// still in flight, has no room left. Image size and origin registers are written through csr_;
// the user must write them only while the stream is idle, as the block does not enforce it. The
// position counters run on across images and are not reset by a register write.
module mask_contour_pixel_extract
   import mcpe_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [ORIGIN_W-1:0]   csr_wdata,
   // pixel beats
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel_value
   // contour point beats
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata    // [16:0] point_x, [33:17] point_y, rest 0
);

`include "mask_contour_pixel_extract_defines.svh"

   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MaxWidthDim  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MaxHeightDim = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] MinDim       = DIM_W'(MIN_DIM);
   localparam int FIFO_DEPTH = 2;

   // Configuration registers
   logic [DIM_REG_W-1:0] width_ff,    width_in;
   logic [DIM_REG_W-1:0] height_ff,   height_in;
   logic [ORIGIN_W-1:0]  origin_x_ff, origin_x_in;
   logic [ORIGIN_W-1:0]  origin_y_ff, origin_y_in;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH:  width_in    = csr_wdata[DIM_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in   = csr_wdata[DIM_REG_W-1:0];
            CSR_ORIGIN_X:     origin_x_in = csr_wdata;
            CSR_ORIGIN_Y:     origin_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_REG_W'(4096);
         height_ff   <= DIM_REG_W'(4096);
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
      end
   end

   // Effective image size, clamped to the supported range
   logic [DIM_W-1:0] width_dim, height_dim, width_lim, height_lim;

   assign width_dim  = DIM_W'(width_ff);
   assign height_dim = DIM_W'(height_ff);

   always_comb begin
      if (width_dim < MinDim) begin
         width_lim = MinDim;
      end else if (width_dim > MaxWidthDim) begin
         width_lim = MaxWidthDim;
      end else begin
         width_lim = width_dim;
      end
      if (height_dim < MinDim) begin
         height_lim = MinDim;
      end else if (height_dim > MaxHeightDim) begin
         height_lim = MaxHeightDim;
      end else begin
         height_lim = height_dim;
      end
   end

   // Handshakes and output buffer occupancy
   logic                            req_accept;
   logic                            rsp_pop;
   logic                            s1_valid_ff, s1_valid_in;
   logic [$clog2(FIFO_DEPTH+1)-1:0] count_ff, count_in;
   logic                            push;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   // room for the beat in flight plus a new one, counting a pop at this edge
   assign req_tready = (DIM_W'(count_ff) + DIM_W'(s1_valid_ff) - DIM_W'(rsp_pop))
                       < DIM_W'(FIFO_DEPTH);

   // Raster position counters
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_inc, row_inc;

   assign col_inc = DIM_W'(col_ff) + DIM_W'(1);
   assign row_inc = DIM_W'(row_ff) + DIM_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_inc >= width_lim) begin
            col_in = '0;
            row_in = (row_inc >= height_lim) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = (DIM_W'(row_ff) >= height_lim) ? '0 : row_ff;
         end
      end
   end

   // Stage 1: pixel flag and position wait for the line store read
   logic             s1_flag_ff, s1_flag_in;
   logic [CW-1:0]    s1_col_ff,  s1_col_in;
   logic [ROW_W-1:0] s1_row_ff,  s1_row_in;
   logic             s1_test_ff, s1_test_in;

   assign s1_valid_in = req_accept;
   assign s1_flag_in  = (req_tdata[PIXEL_W-1:0] != '0);
   assign s1_col_in   = col_ff;
   assign s1_row_in   = row_ff;
   assign s1_test_in  = (DIM_W'(col_ff) >= DIM_W'(2)) && (DIM_W'(row_ff) >= DIM_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_flag_ff <= s1_flag_in;
      s1_col_ff  <= s1_col_in;
      s1_row_ff  <= s1_row_in;
      s1_test_ff <= s1_test_in;
   end

   // Line store: bit 0 holds row r-2, bit 1 holds row r-1 at each column.
   // Reads at column c and the write-back at the previous column never share an address,
   // since the column always steps forward or wraps to zero on an image at least 3 wide.
   logic [1:0] ram_rd_data;
   logic [1:0] ram_wr_data;
   logic       ram_wr_en;

   assign ram_wr_en   = s1_valid_ff;
   assign ram_wr_data = {s1_flag_ff, ram_rd_data[1]};

   mcpe_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // 3x3 window: three columns of (top, middle, bottom), newest column in the high bits
   logic [8:0] window_ff, window_in;

   assign window_in = s1_valid_ff ? {s1_flag_ff, ram_rd_data[1], ram_rd_data[0], window_ff[8:3]}
                                  : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // Contour test and origin offset
   logic [DIM_W:0] sum_x, sum_y;
   point_type      point;

   assign push  = s1_valid_ff && s1_test_ff && window_in[4] && (window_in != 9'h1FF);
   assign sum_x = (DIM_W+1)'(s1_col_ff) - (DIM_W+1)'(1)
                  + (DIM_W+1)'($signed(origin_x_ff));
   assign sum_y = (DIM_W+1)'(s1_row_ff) - (DIM_W+1)'(1)
                  + (DIM_W+1)'($signed(origin_y_ff));
   assign point.point_x = sum_x[POINT_W-1:0];
   assign point.point_y = sum_y[POINT_W-1:0];

   // Output buffer, two beats deep
   point_type fifo_ff [FIFO_DEPTH];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;

   assign wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = rsp_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + ($clog2(FIFO_DEPTH+1))'(push)
                      - ($clog2(FIFO_DEPTH+1))'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= point;
      end
   end

   assign rsp_tdata = {(RSP_DATA_W-2*POINT_W)'(0), fifo_ff[rd_ptr_ff]};

   // Checks
   `MCPE_ASSERT_NOW(a_buffer_bound,
      1'b1, (DIM_W'(count_ff) + DIM_W'(s1_valid_ff)) <= DIM_W'(FIFO_DEPTH),
      "output buffer and stage 1 hold more beats than the buffer depth")
   `MCPE_ASSERT_NEXT(a_accept_to_stage1,
      req_accept, s1_valid_ff,
      "accepted pixel did not reach stage 1")
   `MCPE_ASSERT_NOW(a_line_store_no_collision,
      req_accept && s1_valid_ff, col_ff != s1_col_ff,
      "line store read and write-back hit the same column")
   `MCPE_ASSERT_NOW(a_push_has_room,
      push, (DIM_W'(count_ff) - DIM_W'(rsp_pop)) < DIM_W'(FIFO_DEPTH),
      "contour point pushed into a full output buffer")

endmodule

`default_nettype wire

// ===== dv/tb_mask_contour_pixel_extract.sv =====
module tb_mask_contour_pixel_extract;
   timeunit 1ns;
   timeprecision 1ps;

   import mcpe_pkg::*;

   localparam int MAX_COLS    = 4096;
   localparam int DRAIN_WAIT  = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 3000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [ORIGIN_W-1:0]   csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // [7:0] pixel_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [16:0] point_x, [33:17] point_y, rest 0

   mask_contour_pixel_extract #(
      .MAX_WIDTH(MAX_COLS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block: registers, line stores, window and position
   logic [DIM_REG_W-1:0]       cfg_width;
   logic [DIM_REG_W-1:0]       cfg_height;
   logic signed [ORIGIN_W-1:0] cfg_origin_x;
   logic signed [ORIGIN_W-1:0] cfg_origin_y;
   bit                         upper_flags [MAX_COLS];
   bit                         middle_flags [MAX_COLS];
   logic [8:0]                 window_flags;
   int                         col_pos;
   int                         row_pos;

   point_type pending_points [$];

   int  mismatches    = 0;
   int  pixels_sent   = 0;
   int  points_seen   = 0;
   int  image_wraps   = 0;
   int  input_stalls  = 0;
   int  burst_left    = 0;
   bit  no_gaps       = 1'b0;
   bit  hold_pending  = 1'b0;
   int  hold_left     = 0;
   int  pattern_left  = 0;
   int  stall_pct     = 0;
   int  idle_cycles   = 0;

   function automatic int clamp_dim(input logic [DIM_REG_W-1:0] v, input int hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic logic [7:0] draw_pixel(input int pct_painted);
      if ($urandom_range(99) < pct_painted) return 8'($urandom_range(1, 255));
      return 8'h00;
   endfunction

   function automatic logic [15:0] pick_origin();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Advance the shadow model by one pixel and queue the contour point it completes
   task automatic predict_contour(input logic [7:0] value);
      int        w;
      int        h;
      int        px;
      int        py;
      logic      flag;
      logic      top;
      logic      mid;
      point_type pt;
      begin
         w = clamp_dim(cfg_width, MAX_COLS);
         h = clamp_dim(cfg_height, MAX_HEIGHT);
         flag = (value != 8'h00);
         top = upper_flags[col_pos];
         mid = middle_flags[col_pos];
         upper_flags[col_pos] = mid;
         middle_flags[col_pos] = flag;
         window_flags = {flag, mid, top, window_flags[8:3]};
         // centre painted and not fully surrounded
         if (col_pos >= 2 && row_pos >= 2 && window_flags[4] && window_flags != 9'h1FF) begin
            px = col_pos - 1 + int'(cfg_origin_x);
            py = row_pos - 1 + int'(cfg_origin_y);
            pt.point_x = px[POINT_W-1:0];
            pt.point_y = py[POINT_W-1:0];
            pending_points = {pending_points, pt};
         end
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
               row_pos = 0;
               image_wraps++;
            end
         end else if (row_pos >= h) begin
            row_pos = 0;
            image_wraps++;
         end
      end
   endtask

   // One pixel beat, with the sender's burst and gap pattern
   task automatic send_pixel(input logic [7:0] value);
      int gap;
      begin
         gap = 0;
         if (burst_left <= 0) begin
            if ($urandom_range(4) == 0) begin
               burst_left = $urandom_range(40, 250);
            end else begin
               burst_left = $urandom_range(1, 24);
               gap = $urandom_range(1, 8);
            end
         end
         if (no_gaps) gap = 0;
         @(negedge clock);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= value;
         do @(posedge clock); while (!req_tready);
         predict_contour(value);
         pixels_sent++;
         burst_left--;
      end
   endtask

   // Register write once the stream has drained
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         burst_left = 0;
         while (pending_points.size() != 0) @(posedge clock);
         repeat (DRAIN_WAIT) @(posedge clock);
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= value;
         @(negedge clock);
         csr_we <= 1'b0;
         case (idx)
            CSR_IMAGE_WIDTH:  cfg_width = value[DIM_REG_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_height = value[DIM_REG_W-1:0];
            CSR_ORIGIN_X:     cfg_origin_x = value;
            CSR_ORIGIN_Y:     cfg_origin_y = value;
            default: ;
         endcase
      end
   endtask

   // Run the position back to the top left corner with random pixels
   task automatic finish_image();
      while (col_pos != 0 || row_pos != 0) send_pixel(draw_pixel(50));
   endtask

   // 5x5 image: every pixel bit, interior, empty and edge centres, origin extremes
   task automatic test_small_image();
      logic [7:0] pattern [25];
      begin
         pattern = '{8'd0,   8'd255, 8'd1,   8'd2,   8'd4,
                     8'd8,   8'd16,  8'd32,  8'd64,  8'd128,
                     8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                     8'd7,   8'd9,   8'd0,   8'd3,   8'd200,
                     8'd1,   8'd1,   8'd1,   8'd1,   8'd1};
         write_reg(CSR_IMAGE_WIDTH, 16'd5);
         write_reg(CSR_IMAGE_HEIGHT, 16'd5);
         write_reg(CSR_ORIGIN_X, 16'h8000);
         write_reg(CSR_ORIGIN_Y, 16'h7FFF);
         foreach (pattern[i]) send_pixel(pattern[i]);
      end
   endtask

   // Out-of-range sizes: below 3 act as 3, oversized ones act as the maximum
   task automatic test_size_clamps();
      begin
         write_reg(CSR_ORIGIN_X, 16'h7FFF);
         write_reg(CSR_ORIGIN_Y, 16'h8000);
         for (int i = 0; i < 3; i++) begin
            write_reg(CSR_IMAGE_WIDTH, 16'(i));
            write_reg(CSR_IMAGE_HEIGHT, 16'(2 - i));
            repeat (9) send_pixel(draw_pixel(60));
         end
         // oversized width: a long first row, then narrowed past the current column
         write_reg(CSR_IMAGE_WIDTH, 16'd8191);
         write_reg(CSR_IMAGE_HEIGHT, 16'd0);
         repeat (40) send_pixel(draw_pixel(50));
         write_reg(CSR_IMAGE_WIDTH, 16'd8);
         finish_image();
         // oversized height: narrowest rows, then the height drops below the current row
         write_reg(CSR_ORIGIN_X, 16'h0000);
         write_reg(CSR_ORIGIN_Y, 16'hFFF0);
         write_reg(CSR_IMAGE_WIDTH, 16'd1);
         write_reg(CSR_IMAGE_HEIGHT, 16'd8191);
         repeat (3 * 12) send_pixel(draw_pixel(50));
         write_reg(CSR_IMAGE_HEIGHT, 16'd5);
         finish_image();
      end
   endtask

   // Striped image while the consumer holds off: output fills, input must stall
   task automatic test_backpressure();
      begin
         finish_image();
         write_reg(CSR_IMAGE_WIDTH, 16'd6);
         write_reg(CSR_IMAGE_HEIGHT, 16'd40);
         write_reg(CSR_ORIGIN_X, 16'd0);
         write_reg(CSR_ORIGIN_Y, 16'd0);
         no_gaps = 1'b1;
         hold_pending = 1'b1;
         repeat (240) send_pixel(col_pos[0] ? 8'hFF : 8'h00);
         no_gaps = 1'b0;
      end
   endtask

   // Random images of random size and content, some broken by a mid-image write
   task automatic test_random_images();
      int done;
      int w;
      int h;
      int style;
      int density;
      int x0;
      int x1;
      int y0;
      int y1;
      logic in_rect;
      begin
         done = 0;
         while (done < 520) begin
            finish_image();
            w = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 12);
            write_reg(CSR_IMAGE_WIDTH, 16'(w));
            write_reg(CSR_IMAGE_HEIGHT, 16'(h));
            write_reg(CSR_ORIGIN_X, pick_origin());
            write_reg(CSR_ORIGIN_Y, pick_origin());
            style = $urandom_range(2);
            density = $urandom_range(5, 95);
            x0 = $urandom_range(0, w - 1);
            x1 = $urandom_range(x0, w - 1);
            y0 = $urandom_range(0, h - 1);
            y1 = $urandom_range(y0, h - 1);
            do begin
               // mid-image change: never widen, so no unwritten line store entry is read
               if (row_pos >= 2 && $urandom_range(39) == 0) begin
                  case ($urandom_range(2))
                     0: write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(0, 14)));
                     1: write_reg(CSR_IMAGE_WIDTH,
                                  16'($urandom_range(0, clamp_dim(cfg_width, MAX_COLS))));
                     default: write_reg(CSR_ORIGIN_X, pick_origin());
                  endcase
               end
               in_rect = col_pos >= x0 && col_pos <= x1 && row_pos >= y0 && row_pos <= y1;
               if (style == 0) begin
                  send_pixel(draw_pixel(density));
               end else begin
                  send_pixel(draw_pixel(in_rect ? 97 : 4));
               end
               done++;
            end while (col_pos != 0 || row_pos != 0);
         end
      end
   endtask

   // Consumer: long hold-off on request, otherwise stall pattern of varying density
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left <= 0) begin
            pattern_left = $urandom_range(16, 128);
            case ($urandom_range(4))
               0, 1: stall_pct = 0;
               2: stall_pct = 15;
               3: stall_pct = 40;
               default: stall_pct = 75;
            endcase
         end
         pattern_left--;
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Point checker
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_seen++;
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point beat: x=%0d y=%0d",
                        $signed(rsp_tdata[16:0]), $signed(rsp_tdata[33:17]));
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[16:0] !== want.point_x || rsp_tdata[33:17] !== want.point_y ||
                rsp_tdata[RSP_DATA_W-1:34] !== '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("point mismatch: expected (%0d,%0d) got (%0d,%0d) pad %h",
                           $signed(want.point_x), $signed(want.point_y),
                           $signed(rsp_tdata[16:0]), $signed(rsp_tdata[33:17]),
                           rsp_tdata[RSP_DATA_W-1:34]);
            end
         end
      end
      if (!reset && req_tvalid && !req_tready) input_stalls++;
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d points outstanding",
                  idle_cycles, pending_points.size());
         $display("tb_mask_contour_pixel_extract: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      cfg_width = 13'd4096;
      cfg_height = 13'd4096;
      cfg_origin_x = '0;
      cfg_origin_y = '0;
      window_flags = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_small_image();
      test_size_clamps();
      test_backpressure();
      test_random_images();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d pixels over %0d finished images, %0d contour points checked",
               pixels_sent, image_wraps, points_seen);
      $display("input held back %0d cycles by a full output; %0d mismatches",
               input_stalls, mismatches);
      if (mismatches == 0) begin
         $display("tb_mask_contour_pixel_extract: clean");
      end else begin
         $display("tb_mask_contour_pixel_extract: errors");
      end
      $finish;
   end

endmodule

// ===== mask_contour_pixel_extract.f =====
+incdir+hw/rtl
hw/rtl/mcpe_pkg.sv
hw/rtl/mcpe_ram.sv
hw/rtl/mask_contour_pixel_extract.sv
dv/tb_mask_contour_pixel_extract.sv
